// ===== hw/rtl/dsl_pkg.sv =====
package dsl_pkg;

  localparam int unsigned ValueW = 32;

  typedef enum logic [1:0] {
    OpInsert = 2'd0,
    OpDelete = 2'd1,
    OpDump   = 2'd2,
    OpClear  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNotFound = 2'd1,
    StFull     = 2'd2,
    StEmpty    = 2'd3
  } status_e;

  // Shift commands broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic remove;
    logic rotate;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/descending_sorted_list_top.sv =====
// Channel | Direction | Handshake               | Fields
// --------+-----------+-------------------------+--------------------------
// in      | input     | in_valid_i/in_ready_o   | operation_i, value_i
// out     | output    | out_valid_o/out_ready_i | status_o, item_o, last_o
//
// Insert and delete act on the whole chain at once: every cell compares its entry against the
// value in parallel and shifts by one place; clear only resets the fill count. A dump first
// starts the sequencer, then emits one beat per entry while the chain rotates left so that the
// head cell holds the next entry; after count beats the list is back in order. Reset clears the
// fill count, the output valid flag and the dump sequencer; the cells and the output data are
// not reset. A stalled output freezes the rotation and holds off the input.
module descending_sorted_list_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  dsl_pkg::op_e                       operation_i,
  input  logic signed [dsl_pkg::ValueW-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output dsl_pkg::status_e                   status_o,
  output logic signed [dsl_pkg::ValueW-1:0]  item_o,
  output logic                               last_o
);
  import dsl_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // Fill count and dump sequencer.
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] remain_q, remain_d;
  logic            busy_q, busy_d;

  // Output register.
  logic                     out_valid_q, out_valid_d;
  status_e                  status_q, status_d;
  logic signed [ValueW-1:0] item_q, item_d;
  logic                     last_q, last_d;

  logic signed [ValueW-1:0] val   [CAPACITY];
  logic [CAPACITY-1:0]      gt;
  logic [CAPACITY-1:0]      eq;
  cell_ctrl_t               ctrl;
  logic                     out_free;
  logic                     in_acc;
  logic                     full;
  logic                     found;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !busy_q && out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(CAPACITY));
  // Equal entries are contiguous, so any hit means the first hit is where the
  // greater prefix ends; the cells need no ripple chain to find it.
  assign found      = |eq;

  assign ctrl.insert = in_acc && (operation_i == OpInsert) && !full;
  assign ctrl.remove = in_acc && (operation_i == OpDelete) && found;
  assign ctrl.rotate = busy_q && out_free;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ValueW-1:0] left_val;
    logic                     left_gt;
    logic signed [ValueW-1:0] right_val;

    if (i == 0) begin : g_head
      assign left_val = value_i;
      assign left_gt  = 1'b1;
    end else begin : g_body
      assign left_val = val[i-1];
      assign left_gt  = gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_val = '0;
    end else begin : g_mid
      assign right_val = val[i+1];
    end

    dsl_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .value_i     (value_i),
      .left_val_i  (left_val),
      .left_gt_i   (left_gt),
      .right_val_i (right_val),
      .head_val_i  (val[0]),
      .occ_i       (CntW'(i) < count_q),
      .tail_i      (count_q == CntW'(i + 1)),
      .val_o       (val[i]),
      .gt_o        (gt[i]),
      .eq_o        (eq[i])
    );
  end

  always_comb begin
    count_d     = count_q;
    remain_d    = remain_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    item_d      = item_q;
    last_d      = last_q;

    if (in_acc) begin
      item_d = '0;
      last_d = 1'b1;
      case (operation_i)
        OpInsert: begin
          out_valid_d = 1'b1;
          if (full) begin
            status_d = StFull;
          end else begin
            status_d = StOk;
            count_d  = count_q + CntW'(1);
          end
        end
        OpDelete: begin
          out_valid_d = 1'b1;
          if (found) begin
            status_d = StOk;
            count_d  = count_q - CntW'(1);
          end else begin
            status_d = StNotFound;
          end
        end
        OpDump: begin
          if (count_q == '0) begin
            out_valid_d = 1'b1;
            status_d    = StEmpty;
          end else begin
            busy_d   = 1'b1;
            remain_d = count_q;
          end
        end
        OpClear: begin
          out_valid_d = 1'b1;
          status_d    = StOk;
          count_d     = '0;
        end
        default: begin
          out_valid_d = 1'b1;
          status_d    = StOk;
        end
      endcase
    end else if (ctrl.rotate) begin
      // One dump beat: emit the head entry and rotate it to the tail.
      out_valid_d = 1'b1;
      status_d    = StOk;
      item_d      = val[0];
      last_d      = (remain_q == CntW'(1));
      remain_d    = remain_q - CntW'(1);
      if (remain_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      remain_q    <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      remain_q    <= remain_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    item_q   <= item_d;
    last_q   <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign item_o      = item_q;
  assign last_o      = last_q;

  // The fill count never passes the number of cells.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("fill count exceeds capacity");

  // No new item is taken while a dump is still emitting beats.
  a_busy_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_ready_o)
    else $error("input accepted during dump");

  // Every operation but a dump answers with a single final beat next cycle.
  a_single_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (operation_i != OpDump)) |=> (out_valid_q && last_q))
    else $error("single-beat operation did not produce a final beat");

  // A dump never rotates while the output holds an untaken beat.
  a_rotate_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !ctrl.rotate)
    else $error("chain rotated under a stalled output");

endmodule

// ===== hw/rtl/dsl_cell.sv =====
module dsl_cell (
  input  logic                                 clk_i,
  input  dsl_pkg::cell_ctrl_t                  ctrl_i,
  input  logic signed [dsl_pkg::ValueW-1:0]    value_i,
  input  logic signed [dsl_pkg::ValueW-1:0]    left_val_i,
  input  logic                                 left_gt_i,
  input  logic signed [dsl_pkg::ValueW-1:0]    right_val_i,
  input  logic signed [dsl_pkg::ValueW-1:0]    head_val_i,
  input  logic                                 occ_i,
  input  logic                                 tail_i,
  output logic signed [dsl_pkg::ValueW-1:0]    val_o,
  output logic                                 gt_o,
  output logic                                 eq_o
);
  import dsl_pkg::*;

  logic signed [ValueW-1:0] val_q, val_d;

  // Entries form a descending run, so the strictly greater cells are a prefix.
  assign gt_o  = occ_i && (val_q > value_i);
  assign eq_o  = occ_i && (val_q == value_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.insert && !gt_o) begin
      val_d = left_gt_i ? value_i : left_val_i;
    end else if (ctrl_i.remove && !gt_o) begin
      val_d = right_val_i;
    end else if (ctrl_i.rotate) begin
      val_d = tail_i ? head_val_i : right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule
